[src/dhc_pkg.sv]
package dhc_pkg;

  localparam int VALUE_BITS_DEFAULT = 32;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_F = 8'h46;
  localparam logic [7:0] CHAR_LOWER_X = 8'h78;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [3:0] HEX_TEN    = 4'd10;

  // One finished line handed from the front part to the back part.
  typedef struct packed {
    logic hex_in;   // line was hexadecimal, answer in decimal
    logic wrapped;  // value wrapped while it was read
    logic term;     // negative decimal line: answer with terminate
  } job_ctl_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_CONV,
    B_PFX0,
    B_PFX1,
    B_DIGITS,
    B_TERM
  } back_state_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d > 4'd9) begin
      c = CHAR_UPPER_A + {4'b0000, d - HEX_TEN};
    end else begin
      c = CHAR_ZERO + {4'b0000, d};
    end
    return c;
  endfunction

endpackage

[src/decimal_hex_text_converter.sv]
// Converts text lines between decimal and hexadecimal, one ASCII character per
// item in and one per item out. A line opening with "0x" (uppercase digits) is
// answered with its decimal text; any other line is read as decimal and answered
// with "0x" and uppercase hex without leading zeros. A decimal line opening with
// '-' gives one terminate item (char 0, terminated set) and all later input is
// taken and dropped until reset. Values wrap modulo 2^VALUE_BITS and set the
// overflow flag on every character of that line. Characters are taken one per
// cycle; the front part stalls (full) only when its two-line queue is full. Per
// line the back part first takes the line from the queue. For a decimal answer
// the double-dabble loop then shifts one bit per cycle; the digit scan visits
// one digit position per cycle while the output is not stalled, leading zeros
// included, over the decimal digit count of 2^VALUE_BITS - 1 (10 at 32 bits).
// A hex answer sends the "0x" prefix before its digit scan; a terminate line
// sends its one item. Output stalls (pop low) hold prefix, digits and terminate.
module decimal_hex_text_converter #(
  parameter int VALUE_BITS = dhc_pkg::VALUE_BITS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] ch,
  input  logic       line_end,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_char,
  output logic       last_of_line,
  output logic       overflow,
  output logic       terminated
);

  logic                  q_full;
  logic                  q_push;
  logic [VALUE_BITS-1:0] q_wr_value;
  dhc_pkg::job_ctl_t     q_wr_ctl;
  logic                  q_empty;
  logic                  q_pop;
  logic [VALUE_BITS-1:0] q_rd_value;
  dhc_pkg::job_ctl_t     q_rd_ctl;

  dhc_front #(
    .VALUE_BITS(VALUE_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .ch       (ch),
    .line_end (line_end),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_value  (q_wr_value),
    .q_ctl    (q_wr_ctl)
  );

  dhc_queue #(
    .VALUE_BITS(VALUE_BITS)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wr_value (q_wr_value),
    .wr_ctl   (q_wr_ctl),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .rd_value (q_rd_value),
    .rd_ctl   (q_rd_ctl)
  );

  dhc_back #(
    .VALUE_BITS(VALUE_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_value      (q_rd_value),
    .q_ctl        (q_rd_ctl),
    .q_pop        (q_pop),
    .empty        (empty),
    .pop          (pop),
    .out_char     (out_char),
    .last_of_line (last_of_line),
    .overflow     (overflow),
    .terminated   (terminated)
  );

endmodule

[src/dhc_front.sv]
module dhc_front #(
  parameter int VALUE_BITS = dhc_pkg::VALUE_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic [7:0]            ch,
  input  logic                  line_end,
  input  logic                  q_full,
  output logic                  q_push,
  output logic [VALUE_BITS-1:0] q_value,
  output dhc_pkg::job_ctl_t     q_ctl
);

  logic [VALUE_BITS-1:0] accumulator;
  logic [VALUE_BITS-1:0] accumulator_next;
  logic [1:0]            chars_seen;
  logic [7:0]            first_char;
  logic                  hex_mode;
  logic                  hex_mode_next;
  logic                  wrapped;
  logic                  wrapped_next;
  logic                  stopped;

  logic                  take;
  logic [7:0]            first_eff;
  logic                  is_prefix;
  logic [7:0]            dec_off;
  logic [7:0]            hex_off;
  logic [3:0]            digit;
  logic [VALUE_BITS+3:0] prod;
  logic [VALUE_BITS+3:0] sum;
  logic                  term_line;

  assign full = q_full;
  assign take = push && !full && !stopped;

  assign first_eff = (chars_seen == 2'd0) ? ch : first_char;
  assign is_prefix = (chars_seen == 2'd1) && (first_char == dhc_pkg::CHAR_ZERO)
                     && (ch == dhc_pkg::CHAR_LOWER_X);

  assign dec_off = ch - dhc_pkg::CHAR_ZERO;
  assign hex_off = ch - dhc_pkg::CHAR_UPPER_A;

  always_comb begin
    digit = 4'd0;
    if (ch >= dhc_pkg::CHAR_ZERO && ch <= dhc_pkg::CHAR_NINE) begin
      digit = dec_off[3:0];
    end else if (hex_mode && ch >= dhc_pkg::CHAR_UPPER_A && ch <= dhc_pkg::CHAR_UPPER_F) begin
      digit = hex_off[3:0] + dhc_pkg::HEX_TEN;
    end
  end

  always_comb begin
    if (hex_mode) begin
      prod = {accumulator, 4'b0000};
    end else begin
      prod = {1'b0, accumulator, 3'b000} + {3'b000, accumulator, 1'b0};
    end
    sum = prod + (VALUE_BITS+4)'(digit);
  end

  always_comb begin
    if (is_prefix) begin
      accumulator_next = '0;
      wrapped_next     = 1'b0;
    end else begin
      accumulator_next = sum[VALUE_BITS-1:0];
      wrapped_next     = wrapped || (sum[VALUE_BITS+3:VALUE_BITS] != 4'd0);
    end
    hex_mode_next = hex_mode || is_prefix;
  end

  assign term_line = !hex_mode_next && (first_eff == dhc_pkg::CHAR_MINUS);

  assign q_push         = take && line_end;
  assign q_value        = accumulator_next;
  assign q_ctl.hex_in   = hex_mode_next;
  assign q_ctl.wrapped  = wrapped_next;
  assign q_ctl.term     = term_line;

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator <= '0;
      chars_seen  <= 2'd0;
      first_char  <= 8'd0;
      hex_mode    <= 1'b0;
      wrapped     <= 1'b0;
      stopped     <= 1'b0;
    end else if (take) begin
      if (line_end) begin
        // line done: clear for the next one
        accumulator <= '0;
        chars_seen  <= 2'd0;
        first_char  <= 8'd0;
        hex_mode    <= 1'b0;
        wrapped     <= 1'b0;
        if (term_line) begin
          stopped <= 1'b1;
        end
      end else begin
        accumulator <= accumulator_next;
        first_char  <= first_eff;
        hex_mode    <= hex_mode_next;
        wrapped     <= wrapped_next;
        if (chars_seen != 2'd3) begin
          chars_seen <= chars_seen + 2'd1;
        end
      end
    end
  end

endmodule

[src/dhc_queue.sv]
module dhc_queue #(
  parameter int VALUE_BITS = dhc_pkg::VALUE_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic [VALUE_BITS-1:0] wr_value,
  input  dhc_pkg::job_ctl_t     wr_ctl,
  output logic                  full,
  input  logic                  pop,
  output logic                  empty,
  output logic [VALUE_BITS-1:0] rd_value,
  output dhc_pkg::job_ctl_t     rd_ctl
);

  localparam int Depth = dhc_pkg::QUEUE_DEPTH;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  logic [VALUE_BITS-1:0] value_q [Depth];
  dhc_pkg::job_ctl_t     ctl_q   [Depth];
  logic [PtrW-1:0]       wptr;
  logic [PtrW-1:0]       rptr;
  logic [CntW-1:0]       count;
  logic                  do_push;
  logic                  do_pop;

  assign full     = (count == CntW'(Depth));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign rd_value = value_q[rptr];
  assign rd_ctl   = ctl_q[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      value_q[wptr] <= wr_value;
      ctl_q[wptr]   <= wr_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PtrW'(Depth - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PtrW'(Depth - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[src/dhc_back.sv]
module dhc_back #(
  parameter int VALUE_BITS = dhc_pkg::VALUE_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_empty,
  input  logic [VALUE_BITS-1:0] q_value,
  input  dhc_pkg::job_ctl_t     q_ctl,
  output logic                  q_pop,
  output logic                  empty,
  input  logic                  pop,
  output logic [7:0]            out_char,
  output logic                  last_of_line,
  output logic                  overflow,
  output logic                  terminated
);

  // decimal digits of 2^VALUE_BITS - 1; log10(2) ~ 0.30103
  localparam int NumDigits = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int DigW      = 4 * NumDigits;
  localparam int IdxW      = $clog2(NumDigits);
  localparam int CntW      = $clog2(VALUE_BITS);

  dhc_pkg::back_state_t state;
  dhc_pkg::back_state_t state_next;

  logic [DigW-1:0]       bcd_digits;
  logic [DigW-1:0]       bcd_adj;
  logic [VALUE_BITS-1:0] shift_val;
  logic [CntW-1:0]       cnt;
  logic [IdxW-1:0]       idx;
  logic                  started;
  logic                  line_wrapped;
  logic                  out_valid;

  logic                  can_put;
  logic [3:0]            cur_d;
  logic                  skip;
  logic                  put;
  logic [7:0]            put_char;
  logic                  put_last;
  logic                  put_term;

  assign can_put = !out_valid || pop;
  assign cur_d   = bcd_digits[4*idx +: 4];
  assign skip    = !started && (cur_d == 4'd0) && (idx != '0);
  assign empty   = !out_valid;

  // add 3 to every BCD digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd_digits[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_digits[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_digits[4*i +: 4];
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      dhc_pkg::B_IDLE: begin
        if (!q_empty) begin
          if (q_ctl.term) begin
            state_next = dhc_pkg::B_TERM;
          end else if (q_ctl.hex_in) begin
            state_next = dhc_pkg::B_CONV;
          end else begin
            state_next = dhc_pkg::B_PFX0;
          end
        end
      end
      dhc_pkg::B_CONV: begin
        if (cnt == CntW'(VALUE_BITS - 1)) begin
          state_next = dhc_pkg::B_DIGITS;
        end
      end
      dhc_pkg::B_PFX0: begin
        if (can_put) begin
          state_next = dhc_pkg::B_PFX1;
        end
      end
      dhc_pkg::B_PFX1: begin
        if (can_put) begin
          state_next = dhc_pkg::B_DIGITS;
        end
      end
      dhc_pkg::B_DIGITS: begin
        if (!skip && can_put && idx == '0) begin
          state_next = dhc_pkg::B_IDLE;
        end
      end
      dhc_pkg::B_TERM: begin
        if (can_put) begin
          state_next = dhc_pkg::B_IDLE;
        end
      end
      default: state_next = dhc_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    put      = 1'b0;
    put_char = dhc_pkg::CHAR_NUL;
    put_last = 1'b0;
    put_term = 1'b0;
    unique case (state)
      dhc_pkg::B_IDLE: begin
        q_pop = !q_empty;
      end
      dhc_pkg::B_CONV: begin
        put = 1'b0;
      end
      dhc_pkg::B_PFX0: begin
        put      = can_put;
        put_char = dhc_pkg::CHAR_ZERO;
      end
      dhc_pkg::B_PFX1: begin
        put      = can_put;
        put_char = dhc_pkg::CHAR_LOWER_X;
      end
      dhc_pkg::B_DIGITS: begin
        put      = can_put && !skip;
        put_char = dhc_pkg::digit_char(cur_d);
        put_last = (idx == '0);
      end
      dhc_pkg::B_TERM: begin
        put      = can_put;
        put_last = 1'b1;
        put_term = 1'b1;
      end
      default: put = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dhc_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      line_wrapped <= q_ctl.wrapped;
      shift_val    <= q_value;
      cnt          <= '0;
      idx          <= IdxW'(NumDigits - 1);
      started      <= 1'b0;
      bcd_digits   <= q_ctl.hex_in ? '0 : DigW'(q_value);
    end else if (state == dhc_pkg::B_CONV) begin
      bcd_digits <= {bcd_adj[DigW-2:0], shift_val[VALUE_BITS-1]};
      shift_val  <= {shift_val[VALUE_BITS-2:0], 1'b0};
      cnt        <= cnt + 1'b1;
    end else if (state == dhc_pkg::B_DIGITS) begin
      // drop leading zeros without spending an output slot
      if (skip) begin
        idx <= idx - 1'b1;
      end else if (put) begin
        started <= 1'b1;
        idx     <= idx - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (put) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (put) begin
      out_char     <= put_char;
      last_of_line <= put_last;
      overflow     <= line_wrapped && !put_term;
      terminated   <= put_term;
    end
  end

endmodule

[bench/dhc_answer_checker.sv]
`timescale 1ns / 1ps

module dhc_answer_checker #(
  parameter int VALUE_BITS = dhc_pkg::VALUE_BITS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic       full,
  input  logic [7:0] ch,
  input  logic       line_end,
  input  logic       empty,
  input  logic       pop,
  input  logic [7:0] out_char,
  input  logic       last_of_line,
  input  logic       overflow,
  input  logic       terminated,
  output int         mismatch_count,
  output int         answers_pending
);

  typedef struct packed {
    logic [7:0] c;
    logic       last;
    logic       ovf;
    logic       term;
  } answer_char_t;

  localparam logic [63:0] VALUE_MASK = {64{1'b1}} >> (64 - VALUE_BITS);
  localparam logic [63:0] DEC_RADIX = 64'd10;
  localparam logic [63:0] HEX_RADIX = 64'd16;

  answer_char_t answer_q[$];

  logic [63:0] acc;
  logic [1:0]  seen;
  logic [7:0]  lead;
  logic        hex_line;
  logic        wrap;
  logic        halted;

  initial begin
    mismatch_count = 0;
    answers_pending = 0;
  end

  function automatic logic [3:0] digit_of(input logic [7:0] c, input logic hex);
    logic [3:0] d;
    d = '0;
    if (c >= dhc_pkg::CHAR_ZERO && c <= dhc_pkg::CHAR_NINE) begin
      d = 4'(c - dhc_pkg::CHAR_ZERO);
    end else if (hex && c >= dhc_pkg::CHAR_UPPER_A && c <= dhc_pkg::CHAR_UPPER_F) begin
      d = 4'(c - dhc_pkg::CHAR_UPPER_A) + dhc_pkg::HEX_TEN;
    end
    return d;
  endfunction

  task automatic add_digit(input logic [63:0] radix, input logic [3:0] d);
    if (acc > (VALUE_MASK - 64'(d)) / radix) begin
      wrap = 1'b1;
    end
    acc = (acc * radix + 64'(d)) & VALUE_MASK;
  endtask

  task automatic clear_line();
    acc = '0;
    seen = '0;
    lead = dhc_pkg::CHAR_NUL;
    hex_line = 1'b0;
    wrap = 1'b0;
  endtask

  // Hex lines are answered in decimal, decimal lines in "0x" hex; most significant first.
  task automatic queue_answer();
    logic [7:0] digits[$];
    logic [63:0] v;
    logic [3:0] d;
    v = acc;
    if (hex_line) begin
      while (v != 0) begin
        digits.push_front(dhc_pkg::CHAR_ZERO + 8'(v % DEC_RADIX));
        v = v / DEC_RADIX;
      end
    end else begin
      while (v != 0) begin
        d = v[3:0];
        digits.push_front(d > 4'd9 ? dhc_pkg::CHAR_UPPER_A + 8'(d - dhc_pkg::HEX_TEN)
                                   : dhc_pkg::CHAR_ZERO + 8'(d));
        v = v >> 4;
      end
      answer_q.push_back('{c: dhc_pkg::CHAR_ZERO, last: 1'b0, ovf: wrap, term: 1'b0});
      answer_q.push_back('{c: dhc_pkg::CHAR_LOWER_X, last: 1'b0, ovf: wrap, term: 1'b0});
    end
    if (digits.size() == 0) begin
      digits.push_back(dhc_pkg::CHAR_ZERO);
    end
    foreach (digits[i]) begin
      answer_q.push_back('{c: digits[i], last: (i == digits.size() - 1), ovf: wrap,
                           term: 1'b0});
    end
  endtask

  task automatic take_char(input logic [7:0] c, input logic fin);
    if (!halted) begin
      if (seen == 2'd0) begin
        lead = c;
        add_digit(DEC_RADIX, digit_of(c, 1'b0));
      end else if (seen == 2'd1 && lead == dhc_pkg::CHAR_ZERO
                   && c == dhc_pkg::CHAR_LOWER_X) begin
        hex_line = 1'b1;
        acc = '0;
        wrap = 1'b0;
      end else if (hex_line) begin
        add_digit(HEX_RADIX, digit_of(c, 1'b1));
      end else begin
        add_digit(DEC_RADIX, digit_of(c, 1'b0));
      end
      if (seen != 2'd3) begin
        seen++;
      end
      if (fin) begin
        // a negative decimal line stops the stream for good
        if (!hex_line && lead == dhc_pkg::CHAR_MINUS) begin
          answer_q.push_back('{c: dhc_pkg::CHAR_NUL, last: 1'b1, ovf: 1'b0, term: 1'b1});
          halted = 1'b1;
        end else begin
          queue_answer();
        end
        clear_line();
      end
    end
  endtask

  task automatic compare_field(input string field, input logic [7:0] want_v,
                               input logic [7:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, field, want_v, got_v);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    answer_char_t want;
    if (rst) begin
      clear_line();
      halted = 1'b0;
      answer_q.delete();
    end else begin
      // check the item leaving before adding what this edge brings in
      if (pop && !empty) begin
        if (answer_q.size() == 0) begin
          $display("%0t: unexpected item: expected none, got char %h last %b ovf %b term %b",
                   $time, out_char, last_of_line, overflow, terminated);
          mismatch_count++;
        end else begin
          want = answer_q.pop_front();
          compare_field("out_char", want.c, out_char);
          compare_field("last_of_line", 8'(want.last), 8'(last_of_line));
          compare_field("overflow", 8'(want.ovf), 8'(overflow));
          compare_field("terminated", 8'(want.term), 8'(terminated));
        end
      end
      if (push && !full) begin
        take_char(ch, line_end);
      end
    end
    answers_pending = answer_q.size();
  end

endmodule

[bench/tb_decimal_hex_text_converter.sv]
`timescale 1ns / 1ps

module tb_decimal_hex_text_converter;

  typedef logic [7:0] text_t[$];

  localparam int RUN_ITEMS = 268;
  localparam int CALM_ITEMS = 50;
  localparam int TAIL_CYCLES = 80;
  localparam int WATCHDOG_LIMIT = 2000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic [7:0] ch = 8'h00;
  logic       line_end = 1'b0;
  logic       pop = 1'b0;
  logic       full;
  logic       empty;
  logic [7:0] out_char;
  logic       last_of_line;
  logic       overflow;
  logic       terminated;

  int   mismatch_count;
  int   answers_pending;
  int   items_sent = 0;
  logic calm = 1'b0;
  logic feed_lazy = 1'b0;

  always #10 clk = ~clk;

  decimal_hex_text_converter dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .ch           (ch),
    .line_end     (line_end),
    .empty        (empty),
    .pop          (pop),
    .out_char     (out_char),
    .last_of_line (last_of_line),
    .overflow     (overflow),
    .terminated   (terminated)
  );

  dhc_answer_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .ch              (ch),
    .line_end        (line_end),
    .empty           (empty),
    .pop             (pop),
    .out_char        (out_char),
    .last_of_line    (last_of_line),
    .overflow        (overflow),
    .terminated      (terminated),
    .mismatch_count  (mismatch_count),
    .answers_pending (answers_pending)
  );

  function automatic text_t text_bytes(input string s);
    text_t t;
    for (int i = 0; i < s.len(); i++) begin
      t.push_back(s[i]);
    end
    return t;
  endfunction

  // Mostly well-formed hex or decimal lines, some long enough to wrap, plus noise.
  function automatic text_t random_line();
    text_t t;
    int n;
    int kind;
    int v;
    kind = $urandom_range(0, 9);
    if (kind == 9) begin
      n = $urandom_range(1, 6);
      repeat (n) t.push_back(8'($urandom_range(0, 255)));
    end else if (kind < 4) begin
      t = '{dhc_pkg::CHAR_ZERO, dhc_pkg::CHAR_LOWER_X};
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 10) : $urandom_range(0, 5);
      repeat (n) begin
        v = $urandom_range(0, 15);
        t.push_back(v < 10 ? dhc_pkg::CHAR_ZERO + 8'(v)
                           : dhc_pkg::CHAR_UPPER_A + 8'(v - 10));
      end
    end else begin
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 6);
      repeat (n) t.push_back(dhc_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
    end
    if (kind != 9 && $urandom_range(0, 7) == 0) begin
      t[$urandom_range(0, t.size() - 1)] = 8'($urandom_range(0, 255));
    end
    // hold the leading minus back for the very end
    if (t[0] == dhc_pkg::CHAR_MINUS) begin
      t[0] = dhc_pkg::CHAR_NUL;
    end
    return t;
  endfunction

  task automatic send_char(input logic [7:0] c, input logic fin);
    int gap;
    if (!calm && feed_lazy && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 3);
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push <= 1'b1;
    ch <= c;
    line_end <= fin;
    do @(posedge clk); while (full);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_line(input text_t text);
    feed_lazy = $urandom_range(0, 2) != 0;
    foreach (text[i]) begin
      send_char(text[i], i == text.size() - 1);
    end
  endtask

  initial begin : stimulus
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_line(text_bytes("0"));
    send_line(text_bytes("0x"));
    send_line(text_bytes("0xFFFFFFFF"));
    send_line(text_bytes("4294967296"));
    send_line('{dhc_pkg::CHAR_NUL, 8'hFF});
    send_line(text_bytes("0x-"));

    while (items_sent < RUN_ITEMS) begin
      if (items_sent >= RUN_ITEMS - CALM_ITEMS) begin
        calm = 1'b1;
      end
      send_line(random_line());
    end

    // terminate, then feed lines that must be dropped
    send_line(text_bytes("-7"));
    send_line(text_bytes("0x1F"));
    send_line(text_bytes("12"));
    push <= 1'b0;
    line_end <= 1'b0;

    while (answers_pending != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (mismatch_count == 0) begin
      $display("PASS decimal_hex_text_converter");
    end else begin
      $display("FAIL decimal_hex_text_converter");
    end
    $finish;
  end

  initial begin : drain
    int gap;
    int stretch;
    logic lazy;
    gap = 0;
    stretch = 0;
    lazy = 1'b0;
    forever begin
      @(negedge clk);
      if (stretch == 0) begin
        stretch = $urandom_range(20, 80);
        lazy = $urandom_range(0, 2) != 0;
      end
      stretch--;
      if (gap > 0) begin
        gap--;
        pop <= 1'b0;
      end else if (!calm && lazy && $urandom_range(0, 4) == 0) begin
        gap = $urandom_range(0, 2);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (push && !full) || (pop && !empty)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("FAIL decimal_hex_text_converter");
    $finish;
  end

endmodule
